/* src/sjrf_pkg.sv */
// Shared types, constants and column helpers of the semi-join row filter.
`default_nettype none

package sjrf_pkg;

    localparam int KEY_W         = 32;
    localparam int ROW_COLUMNS   = 3;
    localparam int KEY_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_PROBE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_LEFT_KEY_COL   = 2'd0,
        CFG_RIGHT_KEY_COL  = 2'd1,
        CFG_LEFT_COLS_USED = 2'd2
    } t_cfg_idx;

    // control of the key ring: shift moves every cell one place,
    // rotate feeds the last cell back into the first one
    typedef struct packed {
        logic shift;
        logic rotate;
    } t_chain_ctl;

    function automatic logic [KEY_W-1:0] pick_column(
        input logic [KEY_W-1:0] col_a,
        input logic [KEY_W-1:0] col_b,
        input logic [KEY_W-1:0] col_c,
        input logic [1:0]       sel
    );
        logic [1:0] s;
        logic [KEY_W-1:0] res;
        s = sel;
        if (s > 2'(ROW_COLUMNS - 1)) s = 2'(ROW_COLUMNS - 1);
        case (s)
            2'd0:    res = col_a;
            2'd1:    res = col_b;
            default: res = col_c;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] cols_used(input logic [1:0] cfg);
        logic [1:0] u;
        u = cfg;
        if (u == 2'd0) u = 2'd1;
        if (u > 2'(ROW_COLUMNS)) u = 2'(ROW_COLUMNS);
        return u;
    endfunction

endpackage

`default_nettype wire

/* src/sjrf_cell.sv */
// One key cell of the ring: holds a key and takes its neighbor's on shift.
`default_nettype none

module sjrf_cell
    import sjrf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire logic [KEY_W-1:0] i_key,
    output logic      [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_key;
        end
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

/* src/sjrf_chain.sv */
// Ring of key cells: loads insert at the first cell, a probe search rotates the ring once.
`default_nettype none

module sjrf_chain
    import sjrf_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire t_chain_ctl       i_ctl,
    input  wire logic [KEY_W-1:0] i_load_key,
    output logic      [KEY_W-1:0] o_head_key
);

    logic [KEY_W-1:0] w_key [KEY_DEPTH];
    logic [KEY_W-1:0] w_first_in;

    assign w_first_in = i_ctl.rotate ? w_key[KEY_DEPTH-1] : i_load_key;

    for (genvar g = 0; g < KEY_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            sjrf_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_key   (w_first_in),
                .o_key   (w_key[g])
            );
        end else begin : g_rest
            sjrf_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_key   (w_key[g-1]),
                .o_key   (w_key[g])
            );
        end
    end

    // the last cell is where the probe comparator looks
    assign o_head_key = w_key[KEY_DEPTH-1];

endmodule

`default_nettype wire

/* src/semi_join_row_filter.sv */
// Semi-join row filter top level: command decode, key cache, search control, output register.
// Keys live in a ring of KEY_DEPTH cells, newest first. Clear, load, a probe whose key equals
// the previous probe's key, and a probe into an empty store are done at acceptance. Any other
// probe rotates the whole ring once past a single comparator at its last cell. Its result (if
// any) is written to the output register at the last ring step, and no new request is taken
// until the search has returned to idle. A request is taken only when
// the output register is empty or being emptied in the same cycle. No clearing pass is needed
// after reset.
`default_nettype none

module semi_join_row_filter
    import sjrf_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [1:0]       i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_command,
    input  wire logic [KEY_W-1:0] i_col_a,
    input  wire logic [KEY_W-1:0] i_col_b,
    input  wire logic [KEY_W-1:0] i_col_c,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [KEY_W-1:0] o_out_a,
    output logic      [KEY_W-1:0] o_out_b,
    output logic      [KEY_W-1:0] o_out_c,
    output logic      [KEY_W-1:0] o_kept_index,
    output logic                  o_store_overflowed
);

    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int SW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(KEY_DEPTH);
    localparam logic [SW-1:0] LAST_STEP = SW'(KEY_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [KEY_W-1:0] r_prev_key;
    logic             r_prev_valid;
    logic             r_prev_found;
    logic [KEY_W-1:0] r_kept;
    logic             r_ovf;
    logic [1:0]       r_cfg_lkey;
    logic [1:0]       r_cfg_rkey;
    logic [1:0]       r_cfg_used;
    logic [KEY_W-1:0] r_key;
    logic [SW-1:0]    r_step;
    logic [SW-1:0]    r_thresh;
    logic             r_found;
    logic [KEY_W-1:0] r_row_a;
    logic [KEY_W-1:0] r_row_b;
    logic [KEY_W-1:0] r_row_c;
    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_a;
    logic [KEY_W-1:0] r_out_b;
    logic [KEY_W-1:0] r_out_c;
    logic [KEY_W-1:0] r_out_idx;
    logic             r_out_ovf;

    logic             w_in_acc;
    t_cmd             w_cmd;
    logic [KEY_W-1:0] w_lkey;
    logic [KEY_W-1:0] w_rkey;
    logic [1:0]       w_used;
    logic [KEY_W-1:0] w_row_a;
    logic [KEY_W-1:0] w_row_b;
    logic [KEY_W-1:0] w_row_c;
    logic             w_full;
    logic             w_hit;
    logic [KEY_W-1:0] w_head;
    logic             w_found_fin;
    logic             w_last;
    logic             w_emit;
    t_chain_ctl       w_ctl;

    assign o_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_stall));
    assign w_in_acc = i_valid && !o_stall;
    assign w_cmd    = t_cmd'(i_command);

    assign w_lkey  = pick_column(i_col_a, i_col_b, i_col_c, r_cfg_lkey);
    assign w_rkey  = pick_column(i_col_a, i_col_b, i_col_c, r_cfg_rkey);
    assign w_used  = cols_used(r_cfg_used);
    assign w_row_a = i_col_a;
    assign w_row_b = (w_used >= 2'd2) ? i_col_b : '0;
    assign w_row_c = (w_used >= 2'd3) ? i_col_c : '0;

    assign w_full = (r_count == DEPTH_C);
    assign w_hit  = r_prev_valid && (r_prev_key == w_lkey);

    // ring step t shows the key loaded t-th newest from the far end; only the
    // last r_count steps carry stored keys
    assign w_found_fin = r_found || ((w_head == r_key) && (r_step >= r_thresh));
    assign w_last      = (r_step == LAST_STEP);

    assign w_emit = ((r_state == ST_IDLE) && w_in_acc && (w_cmd == CMD_PROBE)
                     && w_hit && r_prev_found)
                 || ((r_state == ST_SEARCH) && w_last && w_found_fin);

    assign w_ctl.shift  = ((r_state == ST_IDLE) && w_in_acc && (w_cmd == CMD_LOAD) && !w_full)
                       || (r_state == ST_SEARCH);
    assign w_ctl.rotate = (r_state == ST_SEARCH);

    sjrf_chain #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_load_key (w_rkey),
        .o_head_key (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_prev_key   <= '0;
            r_prev_valid <= 1'b0;
            r_prev_found <= 1'b0;
            r_kept       <= '0;
            r_ovf        <= 1'b0;
            r_cfg_lkey   <= 2'd0;
            r_cfg_rkey   <= 2'd0;
            r_cfg_used   <= 2'd3;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEFT_KEY_COL:   r_cfg_lkey <= i_cfg_data;
                    CFG_RIGHT_KEY_COL:  r_cfg_rkey <= i_cfg_data;
                    CFG_LEFT_COLS_USED: r_cfg_used <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_cmd)
                            CMD_CLEAR: begin
                                r_count      <= '0;
                                r_kept       <= '0;
                                r_ovf        <= 1'b0;
                                r_prev_valid <= 1'b0;
                            end
                            CMD_LOAD: begin
                                if (w_full) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_prev_valid <= 1'b0;
                            end
                            CMD_PROBE: begin
                                if (w_hit) begin
                                    // cached answer, nothing to update
                                end else if (r_count == '0) begin
                                    r_prev_key   <= w_lkey;
                                    r_prev_valid <= 1'b1;
                                    r_prev_found <= 1'b0;
                                end else begin
                                    r_key    <= w_lkey;
                                    r_step   <= '0;
                                    r_found  <= 1'b0;
                                    r_thresh <= SW'(DEPTH_C - r_count);
                                    r_row_a  <= w_row_a;
                                    r_row_b  <= w_row_b;
                                    r_row_c  <= w_row_c;
                                    r_state  <= ST_SEARCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SEARCH: begin
                    r_step  <= r_step + SW'(1);
                    r_found <= w_found_fin;
                    if (w_last) begin
                        r_prev_key   <= r_key;
                        r_prev_valid <= 1'b1;
                        r_prev_found <= w_found_fin;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= r_kept;
                r_out_ovf   <= r_ovf;
                if (r_state == ST_SEARCH) begin
                    r_out_a <= r_row_a;
                    r_out_b <= r_row_b;
                    r_out_c <= r_row_c;
                end else begin
                    r_out_a <= w_row_a;
                    r_out_b <= w_row_b;
                    r_out_c <= w_row_c;
                end
                if (r_kept != '1) begin
                    r_kept <= r_kept + KEY_W'(1);
                end
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_a            = r_out_a;
    assign o_out_b            = r_out_b;
    assign o_out_c            = r_out_c;
    assign o_kept_index       = r_out_idx;
    assign o_store_overflowed = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("key count beyond store depth");

    a_search_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_count != '0))
        else $error("search started on an empty store");

    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> o_stall)
        else $error("request taken during a search");

    a_kept_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_kept != '1)) |=> (r_kept == $past(r_kept) + KEY_W'(1)))
        else $error("kept count did not advance on an emitted row");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || !i_stall))
        else $error("result written over a held output");

endmodule

`default_nettype wire
